// ===== rtl/core/ccc_pkg.sv =====
package ccc_pkg;

    typedef enum logic [3:0] {
        CMD_TICK       = 4'd0,
        CMD_SEC_UP     = 4'd1,
        CMD_MIN_UP     = 4'd2,
        CMD_HOUR_UP    = 4'd3,
        CMD_DAY_UP     = 4'd4,
        CMD_MONTH_UP   = 4'd5,
        CMD_YEAR_UP    = 4'd6,
        CMD_SEC_DOWN   = 4'd7,
        CMD_MIN_DOWN   = 4'd8,
        CMD_HOUR_DOWN  = 4'd9,
        CMD_DAY_DOWN   = 4'd10,
        CMD_MONTH_DOWN = 4'd11,
        CMD_YEAR_DOWN  = 4'd12
    } ccc_cmd_t;

    typedef struct packed {
        logic [5:0] sec;
        logic [5:0] min;
        logic [4:0] hour;
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year;
    } ccc_time_t;

    localparam logic [5:0] SEC_LAST   = 6'd59;
    localparam logic [5:0] MIN_LAST   = 6'd59;
    localparam logic [4:0] HOUR_LAST  = 5'd23;
    localparam logic [3:0] MONTH_LAST = 4'd12;
    localparam logic [6:0] YEAR_LAST  = 7'd99;

    localparam logic [4:0] DAY_FIRST   = 5'd1;
    localparam logic [3:0] MONTH_FIRST = 4'd1;

    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 40;

endpackage

// ===== rtl/core/ccc_step.sv =====
module ccc_step
    import ccc_pkg::*;
(
    input  ccc_cmd_t  cmd,
    input  logic      sec_adv,
    input  ccc_time_t cur,
    output ccc_time_t nxt
);

    function automatic logic [4:0] month_len(input logic [3:0] m, input logic [6:0] y);
        logic [4:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd2:    len = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
            default: len = 5'd30;
        endcase
        return len;
    endfunction

    logic up_sec, up_min, up_hour, up_day, up_month, up_year;
    logic dn_sec, dn_min, dn_hour, dn_day, dn_month, dn_year;
    logic [4:0] len_cur;

    assign len_cur = month_len(cur.month, cur.year);

    assign up_sec   = (cmd == CMD_SEC_UP) || sec_adv;
    assign up_min   = (cmd == CMD_MIN_UP) || (up_sec && (cur.sec >= SEC_LAST));
    assign up_hour  = (cmd == CMD_HOUR_UP) || (up_min && (cur.min >= MIN_LAST));
    assign up_day   = (cmd == CMD_DAY_UP) || (up_hour && (cur.hour >= HOUR_LAST));
    assign up_month = (cmd == CMD_MONTH_UP) || (up_day && (cur.day >= len_cur));
    assign up_year  = (cmd == CMD_YEAR_UP) || (up_month && (cur.month >= MONTH_LAST));

    assign dn_sec   = (cmd == CMD_SEC_DOWN);
    assign dn_min   = (cmd == CMD_MIN_DOWN)
                   || (dn_sec && ((cur.sec == 6'd0) || (cur.sec > SEC_LAST)));
    assign dn_hour  = (cmd == CMD_HOUR_DOWN)
                   || (dn_min && ((cur.min == 6'd0) || (cur.min > MIN_LAST)));
    assign dn_day   = (cmd == CMD_DAY_DOWN)
                   || (dn_hour && ((cur.hour == 5'd0) || (cur.hour > HOUR_LAST)));
    assign dn_month = (cmd == CMD_MONTH_DOWN) || (dn_day && (cur.day <= DAY_FIRST));
    assign dn_year  = (cmd == CMD_YEAR_DOWN)
                   || (dn_month && ((cur.month <= MONTH_FIRST) || (cur.month > MONTH_LAST)));

    always_comb begin
        if (up_sec) begin
            nxt.sec = (cur.sec >= SEC_LAST) ? 6'd0 : cur.sec + 6'd1;
        end else if (dn_sec) begin
            nxt.sec = ((cur.sec == 6'd0) || (cur.sec > SEC_LAST)) ? SEC_LAST : cur.sec - 6'd1;
        end else begin
            nxt.sec = cur.sec;
        end

        if (up_min) begin
            nxt.min = (cur.min >= MIN_LAST) ? 6'd0 : cur.min + 6'd1;
        end else if (dn_min) begin
            nxt.min = ((cur.min == 6'd0) || (cur.min > MIN_LAST)) ? MIN_LAST : cur.min - 6'd1;
        end else begin
            nxt.min = cur.min;
        end

        if (up_hour) begin
            nxt.hour = (cur.hour >= HOUR_LAST) ? 5'd0 : cur.hour + 5'd1;
        end else if (dn_hour) begin
            nxt.hour = ((cur.hour == 5'd0) || (cur.hour > HOUR_LAST)) ? HOUR_LAST
                                                                      : cur.hour - 5'd1;
        end else begin
            nxt.hour = cur.hour;
        end

        if (up_month) begin
            nxt.month = (cur.month >= MONTH_LAST) ? MONTH_FIRST : cur.month + 4'd1;
        end else if (dn_month) begin
            nxt.month = ((cur.month <= MONTH_FIRST) || (cur.month > MONTH_LAST))
                      ? MONTH_LAST : cur.month - 4'd1;
        end else begin
            nxt.month = cur.month;
        end

        if (up_year) begin
            nxt.year = (cur.year >= YEAR_LAST) ? 7'd0 : cur.year + 7'd1;
        end else if (dn_year) begin
            nxt.year = ((cur.year == 7'd0) || (cur.year > YEAR_LAST)) ? YEAR_LAST
                                                                      : cur.year - 7'd1;
        end else begin
            nxt.year = cur.year;
        end

        // A borrow out of day one takes the length of the month it lands in.
        if (up_day) begin
            nxt.day = (cur.day >= len_cur) ? DAY_FIRST : cur.day + 5'd1;
        end else if (dn_day) begin
            nxt.day = (cur.day <= DAY_FIRST) ? month_len(nxt.month, nxt.year)
                                             : cur.day - 5'd1;
        end else begin
            nxt.day = cur.day;
        end
    end

endmodule

// ===== rtl/core/calendar_clock_counter_core.sv =====
// Real-time clock and calendar. Every input item is one command (a 10 ms tick, or an
// increment or decrement of second, minute, hour, day, month or two-digit year) and
// gives exactly one result item with the second strobe and the full time and date
// after the command. Increments and decrements carry and borrow through the higher
// fields with leap-year month lengths; year 00 counts as a leap year. The result of each
// item is registered in the cycle after acceptance, and a new item is accepted
// in every cycle while the result register is empty or being taken; the carry chain
// through the calendar fields between the state registers and the result register
// sets the cycle time. TICKS_PER_SECOND ticks make one second. After reset the clock
// reads 00:00:00 on day 1, month 1, year 00.
module calendar_clock_counter_core
    import ccc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 100
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [3:0] command, [4] hold
    input  logic [TDATA_IN_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [0] second_strobe, [6:1] seconds, [12:7] minutes, [17:13] hours,
    // [22:18] day_of_month, [26:23] month_number, [33:27] year_two_digit
    output logic [TDATA_OUT_W-1:0] m_tdata
);

    localparam logic [6:0] PRESCALE_LAST = 7'(TICKS_PER_SECOND - 1);

    logic [6:0]             prescale_reg;
    logic [6:0]             prescale_next;
    ccc_time_t              time_reg;
    ccc_time_t              time_next;
    logic                   m_tvalid_reg;
    logic [TDATA_OUT_W-1:0] m_tdata_reg;
    logic [TDATA_OUT_W-1:0] m_tdata_next;

    ccc_cmd_t cmd;
    logic     hold;
    logic     accept;
    logic     is_tick;
    logic     wrap;
    logic     strobe;
    logic     sec_adv;

    assign cmd     = ccc_cmd_t'(s_tdata[3:0]);
    assign hold    = s_tdata[4];
    assign is_tick = (cmd == CMD_TICK);
    assign wrap    = (prescale_reg >= PRESCALE_LAST);
    assign strobe  = is_tick && wrap;
    assign sec_adv = strobe && !hold;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign prescale_next = !is_tick ? prescale_reg : (wrap ? 7'd0 : prescale_reg + 7'd1);

    ccc_step u_step (
        .cmd     (cmd),
        .sec_adv (sec_adv),
        .cur     (time_reg),
        .nxt     (time_next)
    );

    assign m_tdata_next = {6'd0, time_next.year, time_next.month, time_next.day,
                           time_next.hour, time_next.min, time_next.sec, strobe};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prescale_reg   <= 7'd0;
            time_reg.sec   <= 6'd0;
            time_reg.min   <= 6'd0;
            time_reg.hour  <= 5'd0;
            time_reg.day   <= DAY_FIRST;
            time_reg.month <= MONTH_FIRST;
            time_reg.year  <= 7'd0;
            m_tvalid_reg   <= 1'b0;
        end else if (accept) begin
            prescale_reg <= prescale_next;
            time_reg     <= time_next;
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ccc_pkg::*;

    localparam int TICKS_PER_SECOND = 100;
    localparam int RANDOM_ITEMS     = 850;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int HOLD_OFF_AT      = 300;
    localparam int HOLD_OFF_CYCLES  = 250;
    localparam int DRAIN_CYCLES     = 8;

    localparam logic [3:0] CMD_SPARE_LO = 4'd13;
    localparam logic [3:0] CMD_SPARE_HI = 4'd15;

    typedef struct packed {
        logic      strobe;
        ccc_time_t t;
    } rtc_reading_t;

    typedef struct packed {
        logic [3:0]   cmd;
        logic         hold;
        logic         typed;
        rtc_reading_t want;
    } cmd_row_t;

    typedef enum logic [1:0] {
        RX_STREAM,
        RX_COIN,
        RX_SPARSE
    } rx_mode_t;

    localparam rtc_reading_t AT_RESET = '{
        strobe: 1'b0,
        t: '{sec: 6'd0, min: 6'd0, hour: 5'd0, day: DAY_FIRST, month: MONTH_FIRST, year: 7'd0}
    };
    localparam rtc_reading_t AT_CENTURY_END = '{
        strobe: 1'b0,
        t: '{sec: SEC_LAST, min: MIN_LAST, hour: HOUR_LAST, day: 5'd31, month: MONTH_LAST,
             year: YEAR_LAST}
    };
    localparam rtc_reading_t NO_READING = '0;

    localparam int DIR_ROWS = 23;
    localparam cmd_row_t DIRECTED [DIR_ROWS] = '{
        '{CMD_SPARE_HI,   1'b1, 1'b1, AT_RESET},
        '{CMD_SPARE_LO,   1'b0, 1'b1, AT_RESET},
        '{CMD_SEC_DOWN,   1'b0, 1'b1, AT_CENTURY_END},
        '{CMD_SEC_UP,     1'b1, 1'b1, AT_RESET},
        '{CMD_TICK,       1'b1, 1'b1, AT_RESET},
        '{CMD_TICK,       1'b0, 1'b0, NO_READING},
        '{CMD_MIN_DOWN,   1'b0, 1'b0, NO_READING},
        '{CMD_HOUR_DOWN,  1'b1, 1'b0, NO_READING},
        '{CMD_DAY_DOWN,   1'b0, 1'b0, NO_READING},
        '{CMD_MONTH_DOWN, 1'b0, 1'b0, NO_READING},
        '{CMD_YEAR_DOWN,  1'b1, 1'b0, NO_READING},
        '{CMD_YEAR_UP,    1'b0, 1'b0, NO_READING},
        '{CMD_MONTH_UP,   1'b0, 1'b0, NO_READING},
        '{CMD_DAY_UP,     1'b1, 1'b0, NO_READING},
        '{CMD_HOUR_UP,    1'b0, 1'b0, NO_READING},
        '{CMD_MIN_UP,     1'b0, 1'b0, NO_READING},
        '{CMD_SPARE_HI,   1'b0, 1'b0, NO_READING},
        '{CMD_DAY_DOWN,   1'b0, 1'b0, NO_READING},
        '{CMD_MONTH_UP,   1'b1, 1'b0, NO_READING},
        '{CMD_MONTH_UP,   1'b0, 1'b0, NO_READING},
        '{CMD_DAY_UP,     1'b0, 1'b0, NO_READING},
        '{CMD_MONTH_DOWN, 1'b0, 1'b0, NO_READING},
        '{CMD_DAY_DOWN,   1'b1, 1'b0, NO_READING}
    };

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;

    logic [6:0]   tick_count;
    ccc_time_t    cal;
    rtc_reading_t pending_readings [$];
    int           items_accepted = 0;
    int           err_count = 0;
    int           cycle_count = 0;
    int           burst_left = 0;

    calendar_clock_counter_core #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic logic [4:0] days_in_month();
        case (cal.month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: return 5'd31;
            4'd2: return (cal.year[1:0] == 2'd0) ? 5'd29 : 5'd28;
            default: return 5'd30;
        endcase
    endfunction

    function automatic void bump_year();
        cal.year = (cal.year >= YEAR_LAST) ? 7'd0 : cal.year + 7'd1;
    endfunction

    function automatic void drop_year();
        cal.year = (cal.year == 7'd0 || cal.year > YEAR_LAST) ? YEAR_LAST : cal.year - 7'd1;
    endfunction

    function automatic void bump_month();
        if (cal.month >= MONTH_LAST) begin
            cal.month = MONTH_FIRST;
            bump_year();
        end else begin
            cal.month = cal.month + 4'd1;
        end
    endfunction

    function automatic void drop_month();
        if (cal.month <= MONTH_FIRST || cal.month > MONTH_LAST) begin
            cal.month = MONTH_LAST;
            drop_year();
        end else begin
            cal.month = cal.month - 4'd1;
        end
    endfunction

    function automatic void bump_day();
        if (cal.day >= days_in_month()) begin
            cal.day = DAY_FIRST;
            bump_month();
        end else begin
            cal.day = cal.day + 5'd1;
        end
    endfunction

    function automatic void drop_day();
        if (cal.day <= DAY_FIRST) begin
            drop_month();
            cal.day = days_in_month();
        end else begin
            cal.day = cal.day - 5'd1;
        end
    endfunction

    function automatic void bump_hour();
        if (cal.hour >= HOUR_LAST) begin
            cal.hour = 5'd0;
            bump_day();
        end else begin
            cal.hour = cal.hour + 5'd1;
        end
    endfunction

    function automatic void drop_hour();
        if (cal.hour == 5'd0 || cal.hour > HOUR_LAST) begin
            cal.hour = HOUR_LAST;
            drop_day();
        end else begin
            cal.hour = cal.hour - 5'd1;
        end
    endfunction

    function automatic void bump_min();
        if (cal.min >= MIN_LAST) begin
            cal.min = 6'd0;
            bump_hour();
        end else begin
            cal.min = cal.min + 6'd1;
        end
    endfunction

    function automatic void drop_min();
        if (cal.min == 6'd0 || cal.min > MIN_LAST) begin
            cal.min = MIN_LAST;
            drop_hour();
        end else begin
            cal.min = cal.min - 6'd1;
        end
    endfunction

    function automatic void bump_sec();
        if (cal.sec >= SEC_LAST) begin
            cal.sec = 6'd0;
            bump_min();
        end else begin
            cal.sec = cal.sec + 6'd1;
        end
    endfunction

    function automatic void drop_sec();
        if (cal.sec == 6'd0 || cal.sec > SEC_LAST) begin
            cal.sec = SEC_LAST;
            drop_min();
        end else begin
            cal.sec = cal.sec - 6'd1;
        end
    endfunction

    function automatic rtc_reading_t apply_command(logic [3:0] cmd, logic hold);
        rtc_reading_t r;
        r.strobe = 1'b0;
        case (cmd)
            CMD_TICK: begin
                if (int'(tick_count) + 1 >= TICKS_PER_SECOND) begin
                    tick_count = 7'd0;
                    r.strobe = 1'b1;
                    if (!hold) begin
                        bump_sec();
                    end
                end else begin
                    tick_count = tick_count + 7'd1;
                end
            end
            CMD_SEC_UP:     bump_sec();
            CMD_MIN_UP:     bump_min();
            CMD_HOUR_UP:    bump_hour();
            CMD_DAY_UP:     bump_day();
            CMD_MONTH_UP:   bump_month();
            CMD_YEAR_UP:    bump_year();
            CMD_SEC_DOWN:   drop_sec();
            CMD_MIN_DOWN:   drop_min();
            CMD_HOUR_DOWN:  drop_hour();
            CMD_DAY_DOWN:   drop_day();
            CMD_MONTH_DOWN: drop_month();
            CMD_YEAR_DOWN:  drop_year();
            default: ;
        endcase
        r.t = cal;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
        err_count++;
    endtask

    task automatic offer_command(input logic [3:0] cmd, input logic hold, input logic typed,
                                 input rtc_reading_t want);
        int gap;
        rtc_reading_t predicted;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= TDATA_IN_W'({hold, cmd});
        do @(posedge aclk); while (!s_tready);
        predicted = apply_command(cmd, hold);
        pending_readings.push_back(typed ? want : predicted);
        items_accepted++;
        burst_left--;
    endtask

    always @(posedge aclk) begin
        rtc_reading_t got;
        rtc_reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.strobe  = m_tdata[0];
            got.t.sec   = m_tdata[6:1];
            got.t.min   = m_tdata[12:7];
            got.t.hour  = m_tdata[17:13];
            got.t.day   = m_tdata[22:18];
            got.t.month = m_tdata[26:23];
            got.t.year  = m_tdata[33:27];
            if (pending_readings.size() == 0) begin
                report_mismatch("result item with none pending, seconds", int'(got.t.sec), 0);
            end else begin
                want = pending_readings.pop_front();
                if (got.strobe != want.strobe)
                    report_mismatch("second_strobe", int'(got.strobe), int'(want.strobe));
                if (got.t.sec != want.t.sec)
                    report_mismatch("seconds", int'(got.t.sec), int'(want.t.sec));
                if (got.t.min != want.t.min)
                    report_mismatch("minutes", int'(got.t.min), int'(want.t.min));
                if (got.t.hour != want.t.hour)
                    report_mismatch("hours", int'(got.t.hour), int'(want.t.hour));
                if (got.t.day != want.t.day)
                    report_mismatch("day_of_month", int'(got.t.day), int'(want.t.day));
                if (got.t.month != want.t.month)
                    report_mismatch("month_number", int'(got.t.month), int'(want.t.month));
                if (got.t.year != want.t.year)
                    report_mismatch("year_two_digit", int'(got.t.year), int'(want.t.year));
            end
        end
    end

    initial begin
        rx_mode_t mode;
        int mode_left;
        bit held_off;
        mode = RX_STREAM;
        mode_left = 0;
        held_off = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!held_off && items_accepted >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                if (mode_left == 0) begin
                    mode = rx_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(16, 64);
                end
                mode_left--;
                case (mode)
                    RX_STREAM: m_tready <= 1'b1;
                    RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                    default:   m_tready <= (mode_left % 4 == 0);
                endcase
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("calendar_clock_counter_core verification failed");
        $finish;
    end

    initial begin
        int seg;
        int n;
        int tick_runs;
        logic [3:0] cmd;
        logic hold;
        tick_count = 7'd0;
        cal = AT_RESET.t;
        tick_runs = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (DIRECTED[i]) begin
            offer_command(DIRECTED[i].cmd, DIRECTED[i].hold, DIRECTED[i].typed,
                          DIRECTED[i].want);
        end

        while (items_accepted < DIR_ROWS + RANDOM_ITEMS) begin
            seg = $urandom_range(0, 9);
            if (seg <= 3) begin
                if (tick_runs < 2) begin
                    n = $urandom_range(100, 140);
                    hold = tick_runs[0];
                end else begin
                    n = $urandom_range(20, 130);
                    hold = 1'($urandom_range(0, 1));
                end
                tick_runs++;
                repeat (n) begin
                    if ($urandom_range(0, 15) == 0)
                        offer_command(4'($urandom_range(CMD_SEC_UP, CMD_YEAR_DOWN)),
                                      1'($urandom_range(0, 1)), 1'b0, NO_READING);
                    else
                        offer_command(CMD_TICK, hold, 1'b0, NO_READING);
                end
            end else if (seg <= 6) begin
                n = $urandom_range(4, 20);
                repeat (n) begin
                    offer_command(4'($urandom_range(CMD_SEC_UP, CMD_YEAR_DOWN)),
                                  1'($urandom_range(0, 1)), 1'b0, NO_READING);
                end
            end else if (seg <= 8) begin
                n = $urandom_range(10, 40);
                cmd = 4'($urandom_range(CMD_SEC_UP, CMD_YEAR_DOWN));
                repeat (n) begin
                    offer_command(cmd, 1'($urandom_range(0, 1)), 1'b0, NO_READING);
                end
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) begin
                    offer_command(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)), 1'b0,
                                  NO_READING);
                end
            end
        end

        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("calendar_clock_counter_core verification clean");
        end else begin
            $display("calendar_clock_counter_core verification failed");
        end
        $finish;
    end

endmodule
